// File: rtl/lpd_pkg.sv
// Shared types and constants for the length-prefix deframer.
// No dependencies; every other file of the block but lpd_ifs imports this package.
package lpd_pkg;

   localparam int HEADER_BYTES = 4;
   localparam int HELD_DEPTH   = HEADER_BYTES - 1;
   localparam int HELD_CNT_W   = (HELD_DEPTH > 1) ? $clog2(HEADER_BYTES) : 1;
   localparam int LEN_BYTES    = (HEADER_BYTES < 4) ? HEADER_BYTES : 4;
   localparam int MAX_RESULTS  = HEADER_BYTES;
   localparam int RES_IDX_W    = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
   localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      MODE_HEADER  = 2'd0,
      MODE_PAYLOAD = 2'd1,
      MODE_RAW     = 2'd2
   } mode_type;

   typedef enum logic {
      OP_BYTE    = 1'b0,
      OP_REQUEST = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      KIND_MSG_BYTE   = 3'd0,
      KIND_EMPTY      = 3'd1,
      KIND_RAW_BYTE   = 3'd2,
      KIND_RAW_FINISH = 3'd3,
      KIND_REJECT     = 3'd4
   } kind_type;

   typedef struct packed {
      op_type      operation;
      logic [7:0]  data_byte;
      logic [31:0] raw_length;
   } item_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] byte_out;
      logic       last;
   } result_type;

   // all words caused by one item, oldest in entry 0
   typedef struct packed {
      logic [RES_CNT_W-1:0]               count;
      result_type [MAX_RESULTS-1:0]       entry;
   } bundle_type;

endpackage

// File: rtl/lpd_ifs.sv
// Valid/ready channel interfaces for the deframer's request and response sides.
// No dependencies.
interface lpd_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [7:0]  data_byte;
   logic [31:0] raw_length;

   modport source (output valid, operation, data_byte, raw_length, input ready);
   modport sink   (input valid, operation, data_byte, raw_length, output ready);
endinterface

interface lpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] byte_out;
   logic       last;

   modport source (output valid, kind, byte_out, last, input ready);
   modport sink   (input valid, kind, byte_out, last, output ready);
endinterface

// File: rtl/length_prefix_deframer_raw_mode_unit.sv
// Length-prefix deframer with raw pass-through reads: top level.
// Depends on lpd_pkg, lpd_ifs (channel interfaces), lpd_core and lpd_unpack.
//
// Usage: each req word is either a received byte or a raw-read request.
// Bytes build a 4-byte little-endian length header, then that many bytes
// leave as message bytes with last on the final one; a zero length gives a
// single empty-message word. A raw read of N bytes first replays up to N held
// header bytes, oldest first, then passes received bytes through as raw
// bytes and closes with a raw-finish word (N = 0 finishes at once). A request
// while a message or raw run is open gets one reject word. One req word
// causes zero to four rsp words. Bytes in a message or raw run pass at one req
// word per cycle while rsp is ready; a word that causes k rsp words holds the
// result register until all k have left, as rsp moves one word per cycle
// while ready, and req stalls once the input register is also full. An
// accepted word waits in the input register until the result register can
// take its words, which the parser then writes there. No clearing pass after reset.
module length_prefix_deframer_raw_mode_unit
   import lpd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   lpd_req_if.sink   req_chan,
   lpd_rsp_if.source rsp_chan
);

   // input register: lets req take a word while rsp is stalled
   logic       item_valid_ff, item_valid_in;
   item_type   item_ff, item_in;
   logic       req_fire;
   logic       advance;
   logic       can_load;
   bundle_type bundle;

   // parser moves on whenever the result register can take its words
   assign advance        = item_valid_ff && can_load;
   assign req_chan.ready = !item_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      item_in.operation  = op_type'(req_chan.operation);
      item_in.data_byte  = req_chan.data_byte;
      item_in.raw_length = req_chan.raw_length;
      item_valid_in      = req_fire || (item_valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
   end

   lpd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .bundle  (bundle)
   );

   // words that cause nothing (such as header bytes) never occupy the register
   lpd_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && (bundle.count != '0)),
      .bundle_in (bundle),
      .can_load  (can_load),
      .rsp       (rsp_chan)
   );

endmodule

// File: rtl/lpd_core.sv
// Parser state and single-pass result generation for one item.
// Depends on lpd_pkg.
module lpd_core
   import lpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   output bundle_type bundle
);

   mode_type                         mode_ff, mode_in;
   logic [HELD_CNT_W-1:0]            held_count_ff, held_count_in;
   logic [HELD_DEPTH-1:0][7:0]       held_ff, held_in;
   logic [31:0]                      payload_left_ff, payload_left_in;
   logic [31:0]                      raw_left_ff, raw_left_in;
   logic [31:0]                      header_len;
   logic                             req_fits;
   logic [HELD_CNT_W-1:0]            req_n;

   // length field from held bytes plus the closing byte, little-endian
   always_comb begin
      header_len = '0;
      for (int i = 0; i < LEN_BYTES; i++) begin
         if (i < HELD_DEPTH) begin
            header_len[8*i +: 8] = held_ff[i];
         end else begin
            header_len[8*i +: 8] = item.data_byte;
         end
      end
   end

   assign req_fits = item.raw_length <= {{(32-HELD_CNT_W){1'b0}}, held_count_ff};
   assign req_n    = item.raw_length[HELD_CNT_W-1:0];

   always_comb begin
      mode_in         = mode_ff;
      held_count_in   = held_count_ff;
      held_in         = held_ff;
      payload_left_in = payload_left_ff;
      raw_left_in     = raw_left_ff;
      bundle          = '0;

      if (item.operation == OP_BYTE) begin
         case (mode_ff)
            MODE_RAW: begin
               raw_left_in           = raw_left_ff - 32'd1;
               bundle.count          = RES_CNT_W'(1);
               bundle.entry[0].kind  = KIND_RAW_BYTE;
               bundle.entry[0].byte_out = item.data_byte;
               if (raw_left_ff == 32'd1) begin
                  mode_in               = MODE_HEADER;
                  bundle.entry[0].last  = 1'b1;
                  bundle.entry[1].kind  = KIND_RAW_FINISH;
                  bundle.entry[1].last  = 1'b1;
                  bundle.count          = RES_CNT_W'(2);
               end
            end
            MODE_PAYLOAD: begin
               payload_left_in          = payload_left_ff - 32'd1;
               bundle.count             = RES_CNT_W'(1);
               bundle.entry[0].kind     = KIND_MSG_BYTE;
               bundle.entry[0].byte_out = item.data_byte;
               if (payload_left_ff == 32'd1) begin
                  mode_in              = MODE_HEADER;
                  bundle.entry[0].last = 1'b1;
               end
            end
            default: begin
               // header collection; the spare mode code lands here too
               mode_in = MODE_HEADER;
               if (held_count_ff < HELD_CNT_W'(HELD_DEPTH)) begin
                  held_in[held_count_ff] = item.data_byte;
                  held_count_in          = held_count_ff + HELD_CNT_W'(1);
               end else begin
                  held_count_in = '0;
                  if (header_len == 32'd0) begin
                     bundle.count         = RES_CNT_W'(1);
                     bundle.entry[0].kind = KIND_EMPTY;
                     bundle.entry[0].last = 1'b1;
                  end else begin
                     payload_left_in = header_len;
                     mode_in         = MODE_PAYLOAD;
                  end
               end
            end
         endcase
      end else begin
         case (mode_ff)
            MODE_PAYLOAD, MODE_RAW: begin
               bundle.count         = RES_CNT_W'(1);
               bundle.entry[0].kind = KIND_REJECT;
               bundle.entry[0].last = 1'b1;
            end
            default: begin
               mode_in = MODE_HEADER;
               if (item.raw_length == 32'd0) begin
                  bundle.count         = RES_CNT_W'(1);
                  bundle.entry[0].kind = KIND_RAW_FINISH;
                  bundle.entry[0].last = 1'b1;
               end else if (req_fits) begin
                  // replay the first n held bytes, keep the rest in order
                  for (int i = 0; i < HELD_DEPTH; i++) begin
                     if (i < int'(req_n)) begin
                        bundle.entry[i].kind     = KIND_RAW_BYTE;
                        bundle.entry[i].byte_out = held_ff[i];
                        bundle.entry[i].last     = (i == int'(req_n) - 1);
                     end
                  end
                  bundle.entry[RES_IDX_W'(req_n)].kind = KIND_RAW_FINISH;
                  bundle.entry[RES_IDX_W'(req_n)].last = 1'b1;
                  bundle.count  = RES_CNT_W'(req_n) + RES_CNT_W'(1);
                  held_in       = held_ff >> (8 * int'(req_n));
                  held_count_in = held_count_ff - req_n;
               end else begin
                  for (int i = 0; i < HELD_DEPTH; i++) begin
                     if (i < int'(held_count_ff)) begin
                        bundle.entry[i].kind     = KIND_RAW_BYTE;
                        bundle.entry[i].byte_out = held_ff[i];
                     end
                  end
                  bundle.count  = RES_CNT_W'(held_count_ff);
                  raw_left_in   = item.raw_length
                                  - {{(32-HELD_CNT_W){1'b0}}, held_count_ff};
                  held_count_in = '0;
                  mode_in       = MODE_RAW;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_HEADER;
         held_count_ff   <= '0;
         payload_left_ff <= '0;
         raw_left_ff     <= '0;
      end else if (advance) begin
         mode_ff         <= mode_in;
         held_count_ff   <= held_count_in;
         payload_left_ff <= payload_left_in;
         raw_left_ff     <= raw_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         held_ff <= held_in;
      end
   end

endmodule

// File: rtl/lpd_unpack.sv
// Result register: holds one item's words and hands them out one per cycle while rsp is ready.
// Depends on lpd_pkg and lpd_rsp_if.
module lpd_unpack
   import lpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  bundle_type bundle_in,
   output logic       can_load,
   lpd_rsp_if.source  rsp
);

   logic                          busy_ff, busy_in;
   logic [RES_IDX_W-1:0]          idx_ff, idx_in;
   logic [RES_CNT_W-1:0]          count_ff;
   result_type [MAX_RESULTS-1:0]  entries_ff;
   logic                          fire;
   logic                          at_last;

   assign fire     = busy_ff && rsp.ready;
   assign at_last  = idx_ff == RES_IDX_W'(count_ff - RES_CNT_W'(1));
   assign can_load = !busy_ff || (fire && at_last);

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (fire) begin
         if (at_last) begin
            busy_in = 1'b0;
         end
         idx_in = idx_ff + RES_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         count_ff   <= bundle_in.count;
         entries_ff <= bundle_in.entry;
      end
   end

   assign rsp.valid    = busy_ff;
   assign rsp.kind     = entries_ff[idx_ff].kind;
   assign rsp.byte_out = entries_ff[idx_ff].byte_out;
   assign rsp.last     = entries_ff[idx_ff].last;

endmodule

// File: rtl/lpd_checker.sv
// Port-level checks on the deframer's response channel, bound to the top.
// Depends on lpd_pkg and length_prefix_deframer_raw_mode_unit.
module lpd_checker
   import lpd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_kind,
   input logic [7:0] rsp_byte_out,
   input logic       rsp_last
);

   // a stalled word holds still
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
                                 && $stable(rsp_byte_out) && $stable(rsp_last))
      else $error("rsp word changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid straight after reset");

   // marker words carry no byte and always close the item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_EMPTY || rsp_kind == KIND_RAW_FINISH
                    || rsp_kind == KIND_REJECT) |-> rsp_last && rsp_byte_out == 8'd0)
      else $error("marker word with byte or without last");

   // closing raw byte is always followed at once by the finish word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_kind == KIND_RAW_BYTE && rsp_last
      |=> rsp_valid && rsp_kind == KIND_RAW_FINISH)
      else $error("raw run closed without finish");

endmodule

bind length_prefix_deframer_raw_mode_unit lpd_checker u_lpd_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_kind     (rsp_chan.kind),
   .rsp_byte_out (rsp_chan.byte_out),
   .rsp_last     (rsp_chan.last)
);
